/* hdl/paps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paps_pkg
// Shared types and constants of the port activity probe scheduler.
// ----------------------------------------------------------------------------
package paps_pkg;

  // millisecond time stamps and config register widths
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PORT_W    = 2;
  localparam int unsigned MASK_W    = 4;

  // config reset values
  localparam logic [CFG_W-1:0] TIMEOUT_RST  = 16'd1500;
  localparam logic [CFG_W-1:0] INTERVAL_RST = 16'd100;
  localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd30;

  // item opcodes
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_FRAME = 1'b1
  } paps_op_e;

  // config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT  = 2'd0,
    CFG_INTERVAL = 2'd1,
    CFG_WINDOW   = 2'd2
  } paps_cfg_idx_e;

  // current config values
  typedef struct packed {
    logic [CFG_W-1:0] timeout;
    logic [CFG_W-1:0] interval;
    logic [CFG_W-1:0] window;
  } paps_cfg_t;

  // per-port status flags
  typedef struct packed {
    logic capture;
    logic connected;
    logic probing;
  } paps_status_t;

endpackage

/* hdl/paps_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paps_cfg_regs
// Config register file: activity timeout, probe interval and probe window.
// ----------------------------------------------------------------------------
module paps_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [paps_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [paps_pkg::CFG_W-1:0]        cfg_data_i,
  output paps_pkg::paps_cfg_t               cfg_o
);
  import paps_pkg::*;

  paps_cfg_t cfg_q, cfg_d;

  // writes are always taken
  assign cfg_ready_o = 1'b1;

  // register decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (paps_cfg_idx_e'(cfg_index_i))
        CFG_TIMEOUT:  cfg_d.timeout  = cfg_data_i;
        CFG_INTERVAL: cfg_d.interval = cfg_data_i;
        CFG_WINDOW:   cfg_d.window   = cfg_data_i;
        default:      cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout  <= TIMEOUT_RST;
      cfg_q.interval <= INTERVAL_RST;
      cfg_q.window   <= WINDOW_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/paps_port_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paps_port_unit
// State of one port: timeout drop, probe window scheduling, frame stamping.
// ----------------------------------------------------------------------------
module paps_port_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            tick_i,
  input  logic                            frame_i,
  input  logic [paps_pkg::STAMP_W-1:0]    now_i,
  input  paps_pkg::paps_cfg_t             cfg_i,
  output paps_pkg::paps_status_t          status_d_o
);
  import paps_pkg::*;

  logic               connected_q, connected_d;
  logic               capture_q, capture_d;
  logic               probe_q, probe_d;
  logic [STAMP_W-1:0] last_seen_q, last_seen_d;
  logic [STAMP_W-1:0] probe_start_q, probe_start_d;
  logic [STAMP_W-1:0] last_probe_q, last_probe_d;

  logic [STAMP_W-1:0] seen_age, probe_age, window_age;
  logic               drop;
  logic               conn_1, cap_1, probe_1;

  // modulo 2^32 ages against the new clock value
  assign seen_age   = now_i - last_seen_q;
  assign probe_age  = now_i - last_probe_q;
  assign window_age = now_i - probe_start_q;

  // activity timeout
  assign drop    = connected_q && (seen_age > {{(STAMP_W-CFG_W){1'b0}}, cfg_i.timeout});
  assign conn_1  = connected_q && !drop;
  assign cap_1   = capture_q && !drop;
  assign probe_1 = probe_q && !drop;

  // next state for tick and frame
  always_comb begin
    connected_d   = connected_q;
    capture_d     = capture_q;
    probe_d       = probe_q;
    last_seen_d   = last_seen_q;
    probe_start_d = probe_start_q;
    last_probe_d  = last_probe_q;
    if (tick_i) begin
      connected_d = conn_1;
      capture_d   = cap_1;
      probe_d     = probe_1;
      if (conn_1) begin
        capture_d = 1'b1;
      end else if (!cap_1) begin
        if (probe_age >= {{(STAMP_W-CFG_W){1'b0}}, cfg_i.interval}) begin
          capture_d     = 1'b1;
          probe_d       = 1'b1;
          probe_start_d = now_i;
          last_probe_d  = now_i;
        end
      end else if (probe_1 &&
                   window_age >= {{(STAMP_W-CFG_W){1'b0}}, cfg_i.window}) begin
        probe_d   = 1'b0;
        capture_d = 1'b0;
      end
    end else if (frame_i && capture_q) begin
      last_seen_d = now_i;
      if (!connected_q) begin
        connected_d = 1'b1;
        probe_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      connected_q   <= 1'b0;
      capture_q     <= 1'b0;
      probe_q       <= 1'b0;
      last_seen_q   <= '0;
      probe_start_q <= '0;
      last_probe_q  <= '0;
    end else begin
      connected_q   <= connected_d;
      capture_q     <= capture_d;
      probe_q       <= probe_d;
      last_seen_q   <= last_seen_d;
      probe_start_q <= probe_start_d;
      last_probe_q  <= last_probe_d;
    end
  end

  assign status_d_o.capture   = capture_d;
  assign status_d_o.connected = connected_d;
  assign status_d_o.probing   = probe_d;

endmodule

/* hdl/port_activity_probe_scheduler_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_activity_probe_scheduler_unit
// Per-port activity monitor with duty-cycled capture probing.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | sink      | in_valid_i / in_ready_o | opcode_i, port_index_i
//  out     | source    | out_valid_o/out_ready_i | capture/connected/probing
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the result is not stalled; a result passes
// through the input register, then the port update into the result register.
// All port state updates from the input register as the result register loads.
// Reset clears the clock, all port state and loads the config defaults.
// A stalled result holds the input register; a new item is taken whenever
// the input register is empty or moves on in the same cycle.
// ----------------------------------------------------------------------------
module port_activity_probe_scheduler_unit #(
  parameter int unsigned PORTS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              opcode_i,
  input  logic [paps_pkg::PORT_W-1:0]       port_index_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [paps_pkg::MASK_W-1:0]       capture_mask_o,
  output logic [paps_pkg::MASK_W-1:0]       connected_mask_o,
  output logic [paps_pkg::MASK_W-1:0]       probing_mask_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [paps_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [paps_pkg::CFG_W-1:0]        cfg_data_i
);
  import paps_pkg::*;

  paps_cfg_t          cfg;
  paps_status_t       status_d [PORTS];

  logic               in_valid_q;
  logic               opcode_q;
  logic [PORT_W-1:0]  port_q;
  logic               out_valid_q, out_valid_d;
  logic [MASK_W-1:0]  cap_mask_q, cap_mask_d;
  logic [MASK_W-1:0]  conn_mask_q, conn_mask_d;
  logic [MASK_W-1:0]  probe_mask_q, probe_mask_d;
  logic [STAMP_W-1:0] now_q, now_d;
  logic               proc_en;
  logic               tick_en;
  logic               frame_en;

  // config registers
  paps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // handshake: the held item moves on when the result slot is free
  assign proc_en    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc_en;
  assign tick_en    = proc_en && (paps_op_e'(opcode_q) == OP_TICK);
  assign frame_en   = proc_en && (paps_op_e'(opcode_q) == OP_FRAME);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      opcode_q <= opcode_i;
      port_q   <= port_index_i;
    end
  end

  // millisecond clock, a tick advances it before the ports look at it
  assign now_d = tick_en ? now_q + STAMP_W'(1) : now_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '0;
    end else begin
      now_q <= now_d;
    end
  end

  // per-port state
  for (genvar p = 0; p < PORTS; p++) begin : g_port
    localparam logic [31:0] PortNum = p;
    logic frame_hit;

    assign frame_hit = frame_en && ({{(32-PORT_W){1'b0}}, port_q} == PortNum);

    paps_port_unit u_port (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tick_i     (tick_en),
      .frame_i    (frame_hit),
      .now_i      (now_d),
      .cfg_i      (cfg),
      .status_d_o (status_d[p])
    );
  end

  // masks of the updated state, ports past the mask width are cut off
  for (genvar m = 0; m < MASK_W; m++) begin : g_mask
    if (m < PORTS) begin : g_live
      assign cap_mask_d[m]   = status_d[m].capture;
      assign conn_mask_d[m]  = status_d[m].connected;
      assign probe_mask_d[m] = status_d[m].probing;
    end else begin : g_none
      assign cap_mask_d[m]   = 1'b0;
      assign conn_mask_d[m]  = 1'b0;
      assign probe_mask_d[m] = 1'b0;
    end
  end

  // result register
  assign out_valid_d = proc_en || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_en) begin
      cap_mask_q   <= cap_mask_d;
      conn_mask_q  <= conn_mask_d;
      probe_mask_q <= probe_mask_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign capture_mask_o   = cap_mask_q;
  assign connected_mask_o = conn_mask_q;
  assign probing_mask_o   = probe_mask_q;

  // connected ports always have capture on
  a_conn_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((connected_mask_o & ~capture_mask_o) == '0))
    else $error("connected port without capture");

  // an open probe window always has capture on
  a_probe_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((probing_mask_o & ~capture_mask_o) == '0))
    else $error("probe window without capture");

  // a port never probes while connected
  a_conn_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((probing_mask_o & connected_mask_o) == '0))
    else $error("connected port still probing");

  // a processed item always lands in the result register
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_en |=> out_valid_q)
    else $error("processed item lost");

  // the clock moves by one on a tick and holds otherwise
  a_clock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick_en |=> (now_q == $past(now_q)))
    else $error("clock moved without tick");

endmodule
